// ===== src/wft_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the weather-fax tone generator.
`default_nettype none

package wft_pkg;

  // Phase accumulator and sine table geometry
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned SINE_W    = 12;
  localparam int unsigned QTR_SIZE  = 1 << (SINE_W - 2);
  localparam int unsigned AMPLITUDE = 18022;

  // Table angle per index, 2*pi over the full wave
  localparam real ANG_STEP = 6.28318530717958647692 / real'(4 * QTR_SIZE);

  // Image geometry limits
  localparam int unsigned MIN_WIDTH = 160;
  localparam int unsigned MAX_WIDTH = 1600;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [14:0] qsine_t [0:QTR_SIZE];

  // round(AMPLITUDE * sin(2*pi*i/2^SINE_W)) over the first quarter, endpoints included
  function automatic qsine_t gen_qsine();
    qsine_t tbl;
    real    ang;
    int     i;
    for (i = 0; i <= int'(QTR_SIZE); i++) begin
      ang    = ANG_STEP * real'(i);
      tbl[i] = 15'($rtoi(real'(AMPLITUDE) * $sin(ang) + 0.5));
    end
    return tbl;
  endfunction

  localparam qsine_t QSINE = gen_qsine();

  typedef enum logic [2:0] {
    SEG_LEAD    = 3'd0,
    SEG_PHASING = 3'd1,
    SEG_IMAGE   = 3'd2,
    SEG_TAIL    = 3'd3,
    SEG_DONE    = 3'd4
  } seg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEAD_LEN    = 3'd0,
    CFG_LINE_LEN    = 3'd1,
    CFG_IMAGE_LINES = 3'd2,
    CFG_IMAGE_WIDTH = 3'd3,
    CFG_TAIL_LEN    = 3'd4,
    CFG_BLACK_STEP  = 3'd5,
    CFG_WHITE_STEP  = 3'd6
  } cfg_idx_t;

  // Which divide a start request runs
  typedef enum logic [1:0] {
    DIV_STEP = 2'd0,
    DIV_LINE = 2'd1,
    DIV_COL  = 2'd2
  } div_op_t;

  typedef struct packed {
    logic    take_in;
    logic    tick;
    logic    step_fix;
    logic    apply;
    logic    line_fast;
    logic    line_div_upd;
    logic    norm_adv;
    logic    col_clamp;
    logic    col_mul;
    logic    col_fix;
    logic    div_start;
    div_op_t div_op;
    logic    load_out;
  } wft_cmd_t;

  typedef struct packed {
    logic seg_done;
    logic seg_image;
    logic norm_adv;
    logic div_busy;
    logic line_adv;
    logic line_fast;
    logic col_needed;
    logic col_clamp;
  } wft_sts_t;

endpackage

`default_nettype wire

// ===== src/wft_in_if.sv =====
// Input channel: one beat per audio tick, carrying the gray value of the requested pixel.
`default_nettype none

interface wft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray;

  modport source (output valid, output gray, input ready);
  modport sink   (input valid, input gray, output ready);
endinterface

`default_nettype wire

// ===== src/wft_out_if.sv =====
// Result channel: one beat per audio tick with the sample and the next pixel request.
`default_nettype none

interface wft_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic        [2:0]  segment;
  logic        [10:0] next_col;
  logic        [13:0] next_row;
  logic               next_needs_pixel;

  modport source (output valid, output sample, output segment, output next_col,
                  output next_row, output next_needs_pixel, input ready);
  modport sink   (input valid, input sample, input segment, input next_col,
                  input next_row, input next_needs_pixel, output ready);
endinterface

`default_nettype wire

// ===== src/wft_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by line and column math.
`default_nettype none

module wft_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [27:0] rem_init,
  input  logic [31:0] dvd_init,
  input  logic [5:0]  bits,
  input  logic [27:0] divisor,
  output logic        busy,
  output logic [31:0] quotient,
  output logic [27:0] remainder
);

  logic [27:0] rem_r;
  logic [31:0] quo_r;
  logic [27:0] dsr_r;
  logic [5:0]  cnt_r;
  logic [28:0] pre;
  logic [28:0] diff;
  logic        ge;

  // Trial subtract of the divisor from the partial remainder
  always_comb begin
    pre  = {rem_r, quo_r[31]};
    ge   = pre >= {1'b0, dsr_r};
    diff = pre - {1'b0, dsr_r};
  end

  // Iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= bits;
    end else if (cnt_r != 6'd0) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      quo_r <= dvd_init;
      dsr_r <= divisor;
    end else if (cnt_r != 6'd0) begin
      rem_r <= ge ? diff[27:0] : pre[27:0];
      quo_r <= {quo_r[30:0], ge};
    end
  end

  assign busy      = cnt_r != 6'd0;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== src/wft_datapath.sv =====
// Datapath: config registers, segment and line state, phase accumulator, sine ROM, divider.
`default_nettype none

module wft_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wft_pkg::wft_cmd_t                    cmd,
  output wft_pkg::wft_sts_t                    sts,
  input  logic [7:0]                           in_gray,
  input  logic                                 cfg_we,
  input  logic [wft_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wft_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic signed [15:0]                   out_sample,
  output logic [2:0]                           out_segment,
  output logic [10:0]                          out_next_col,
  output logic [13:0]                          out_next_row,
  output logic                                 out_next_needs_pixel
);
  import wft_pkg::*;

  // Configuration registers
  logic [19:0] lead_len_r;
  logic [27:0] line_len_r;
  logic [13:0] image_lines_r;
  logic [10:0] image_width_r;
  logic [19:0] tail_len_r;
  logic [31:0] black_step_r;
  logic [31:0] white_step_r;

  // Derived from configuration, refreshed every cycle
  logic [33:0] img_len_r;
  logic [31:0] absd_r;
  logic        dneg_r;

  // Sequencer state
  seg_t        seg_r;
  logic [33:0] count_r;
  logic [27:0] in_line_r;
  logic [13:0] line_r;
  logic [PHASE_W-1:0] phase_r;

  // Per-tick working registers
  logic [7:0]  gray_r;
  seg_t        tick_seg_r;
  logic [31:0] step_r;
  logic [39:0] prod_r;
  logic [38:0] colprod_r;
  logic [10:0] col_r;
  logic signed [15:0] sample_r;

  // Divide by 255: running quotient and remainder
  logic [31:0] q255_r;
  logic [39:0] r255_r;
  logic        r255_busy;

  // Sine ROM read port
  logic [14:0] rom_q_r;
  logic        rom_neg_r;
  logic [10:0] rom_idx;

  // Result register
  logic signed [15:0] out_sample_r;
  seg_t        out_seg_r;
  logic [10:0] out_col_r;
  logic [13:0] out_row_r;
  logic        out_needs_r;

  // Combinational helpers
  logic [13:0] h_eff;
  logic [10:0] w_eff;
  logic        line_nz;
  logic [28:0] phase_sum;
  logic [41:0] img_sum;
  logic [33:0] seg_len;
  logic [32:0] il25;
  logic        is_black;
  logic [32:0] center_sum;
  logic [31:0] tick_step;
  logic [28:0] t_line;
  logic        line_ge;
  logic [15:0] rom_ext;
  logic [15:0] sample_val;
  logic [13:0] row_clamp;
  logic [39:0] step_x;
  logic        step_start;
  logic        long_start;

  // Divider hookup
  logic        div_busy;
  logic [31:0] div_quot;
  logic [27:0] div_rem;
  logic [27:0] div_rem_init;
  logic [31:0] div_dvd_init;
  logic [5:0]  div_bits;
  logic [27:0] div_dsr;

  // Row counter saturates at the 14-bit cap
  function automatic logic [13:0] sat_line(input logic [13:0] base, input logic [28:0] inc);
    logic [29:0] sum;
    sum = 30'(base) + 30'(inc);
    return (sum[29:14] != 16'd0) ? 14'h3fff : sum[13:0];
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_len_r    <= 20'd96000;
      line_len_r    <= 28'd6144000;
      image_lines_r <= 14'd1;
      image_width_r <= 11'd800;
      tail_len_r    <= 20'd72000;
      black_step_r  <= 32'd134217728;
      white_step_r  <= 32'd205802087;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEAD_LEN:    lead_len_r    <= cfg_wdata[19:0];
        CFG_LINE_LEN:    line_len_r    <= cfg_wdata[27:0];
        CFG_IMAGE_LINES: image_lines_r <= cfg_wdata[13:0];
        CFG_IMAGE_WIDTH: image_width_r <= cfg_wdata[10:0];
        CFG_TAIL_LEN:    tail_len_r    <= cfg_wdata[19:0];
        CFG_BLACK_STEP:  black_step_r  <= cfg_wdata;
        CFG_WHITE_STEP:  white_step_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective geometry and segment lengths
  always_comb begin
    h_eff = (image_lines_r == 14'd0) ? 14'd1 : image_lines_r;
    if (image_width_r < 11'(MIN_WIDTH)) begin
      w_eff = 11'(MIN_WIDTH);
    end else if (image_width_r > 11'(MAX_WIDTH)) begin
      w_eff = 11'(MAX_WIDTH);
    end else begin
      w_eff = image_width_r;
    end
    line_nz   = line_len_r != 28'd0;
    phase_sum = {1'b0, line_len_r} + 29'd32;
    img_sum   = 42'(line_len_r) * 42'(h_eff) + 42'd255;
    unique case (seg_r)
      SEG_LEAD:    seg_len = 34'(lead_len_r);
      SEG_PHASING: seg_len = 34'(phase_sum[28:6]);
      SEG_IMAGE:   seg_len = img_len_r;
      SEG_TAIL:    seg_len = 34'(tail_len_r);
      default:     seg_len = '0;
    endcase
  end

  // Config-derived values, registered so a new item sees them settled
  always_ff @(posedge clk) begin
    img_len_r <= img_sum[41:8];
    dneg_r    <= white_step_r < black_step_r;
    absd_r    <= (white_step_r < black_step_r) ? black_step_r - white_step_r
                                               : white_step_r - black_step_r;
  end

  // Step selection for the non-image segments
  always_comb begin
    il25       = {1'b0, in_line_r, 4'b0} + {2'b0, in_line_r, 3'b0} + {5'b0, in_line_r};
    is_black   = il25 < {4'b0, line_len_r, 1'b0};
    center_sum = {1'b0, black_step_r} + {1'b0, white_step_r};
    if (seg_r == SEG_PHASING) begin
      tick_step = is_black ? black_step_r : white_step_r;
    end else begin
      tick_step = center_sum[32:1];
    end
  end

  // Line position advance
  always_comb begin
    t_line  = {1'b0, in_line_r} + 29'd256;
    line_ge = t_line >= {1'b0, line_len_r};
  end

  // Sine ROM, quarter wave mirrored by the top two phase bits
  always_comb begin
    if (phase_r[PHASE_W-2]) begin
      rom_idx = 11'(QTR_SIZE) - {1'b0, phase_r[PHASE_W-3 -: SINE_W-2]};
    end else begin
      rom_idx = {1'b0, phase_r[PHASE_W-3 -: SINE_W-2]};
    end
    rom_ext    = {1'b0, rom_q_r};
    sample_val = rom_neg_r ? 16'd0 - rom_ext : rom_ext;
  end

  always_ff @(posedge clk) begin
    rom_q_r   <= QSINE[rom_idx];
    rom_neg_r <= phase_r[PHASE_W-1];
  end

  // Sequencer state: segment, count, line position, row, phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r     <= SEG_LEAD;
      count_r   <= '0;
      in_line_r <= '0;
      line_r    <= '0;
      phase_r   <= '0;
    end else if (cmd.norm_adv) begin
      seg_r     <= seg_t'(seg_r + 3'd1);
      count_r   <= '0;
      in_line_r <= '0;
      line_r    <= '0;
    end else if (cmd.apply) begin
      phase_r <= phase_r + step_r;
      count_r <= count_r + 34'd1;
      if (cmd.line_fast) begin
        in_line_r <= line_ge ? 28'(t_line - {1'b0, line_len_r}) : t_line[27:0];
        line_r    <= sat_line(line_r, 29'(line_ge));
      end
    end else if (cmd.line_div_upd) begin
      in_line_r <= div_rem;
      line_r    <= sat_line(line_r, div_quot[28:0]);
    end
  end

  // Per-tick working registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      gray_r <= in_gray;
    end
    if (cmd.tick) begin
      tick_seg_r <= seg_r;
      step_r     <= tick_step;
      prod_r     <= 40'(gray_r) * 40'(absd_r);
      if (seg_r == SEG_DONE) begin
        sample_r <= '0;
      end
    end
    if (cmd.step_fix) begin
      step_r <= dneg_r ? black_step_r - q255_r : black_step_r + q255_r;
    end
    if (cmd.apply) begin
      sample_r <= sample_val;
    end
    if (cmd.col_mul) begin
      colprod_r <= 39'(in_line_r) * 39'(w_eff);
    end
    if (cmd.col_clamp) begin
      col_r <= w_eff - 11'd1;
    end else if (cmd.col_fix) begin
      col_r <= div_quot[10:0];
    end
  end

  // Divide by 255: since 256 = 255 + 1, each pass moves the bytes above the low one
  // into the quotient and folds them back into the remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q255_r <= '0;
      r255_r <= '0;
    end else if (step_start) begin
      q255_r <= '0;
      r255_r <= step_x;
    end else if (r255_r[39:8] != 32'd0) begin
      q255_r <= q255_r + r255_r[39:8];
      r255_r <= 40'(r255_r[7:0]) + 40'(r255_r[39:8]);
    end else if (r255_r[7:0] == 8'hFF) begin
      q255_r <= q255_r + 32'd1;
      r255_r <= '0;
    end
  end

  assign r255_busy = (r255_r[39:8] != 32'd0) || (r255_r[7:0] == 8'hFF);

  // Divider operand alignment per operation
  always_comb begin
    step_x     = prod_r + 40'd127;
    step_start = cmd.div_start && (cmd.div_op == DIV_STEP);
    long_start = cmd.div_start && (cmd.div_op != DIV_STEP);
    unique case (cmd.div_op)
      DIV_LINE: begin
        div_rem_init = '0;
        div_dvd_init = {t_line, 3'b0};
        div_bits     = 6'd29;
        div_dsr      = line_len_r;
      end
      DIV_COL: begin
        div_rem_init = colprod_r[38:11];
        div_dvd_init = {colprod_r[10:0], 21'b0};
        div_bits     = 6'd11;
        div_dsr      = line_len_r;
      end
      default: begin
        div_rem_init = '0;
        div_dvd_init = '0;
        div_bits     = '0;
        div_dsr      = '0;
      end
    endcase
  end

  wft_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (long_start),
    .rem_init  (div_rem_init),
    .dvd_init  (div_dvd_init),
    .bits      (div_bits),
    .divisor   (div_dsr),
    .busy      (div_busy),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Status back to the controller
  always_comb begin
    sts.seg_done   = seg_r == SEG_DONE;
    sts.seg_image  = seg_r == SEG_IMAGE;
    sts.norm_adv   = (seg_r != SEG_DONE) && (count_r >= seg_len);
    sts.div_busy   = div_busy || r255_busy;
    sts.line_adv   = ((tick_seg_r == SEG_PHASING) || (tick_seg_r == SEG_IMAGE)) && line_nz;
    sts.line_fast  = t_line < {line_len_r, 1'b0};
    sts.col_needed = (seg_r == SEG_IMAGE) && line_nz;
    sts.col_clamp  = in_line_r >= line_len_r;
  end

  // Result register
  assign row_clamp = (line_r > h_eff - 14'd1) ? h_eff - 14'd1 : line_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r <= sample_r;
      out_seg_r    <= tick_seg_r;
      out_needs_r  <= sts.col_needed;
      out_col_r    <= sts.col_needed ? col_r : '0;
      out_row_r    <= sts.col_needed ? row_clamp : '0;
    end
  end

  assign out_sample           = out_sample_r;
  assign out_segment          = out_seg_r;
  assign out_next_col         = out_col_r;
  assign out_next_row         = out_row_r;
  assign out_next_needs_pixel = out_needs_r;

endmodule

`default_nettype wire

// ===== src/wft_ctrl.sv =====
// Controller: sequences one audio tick through normalize, step, update and column phases.
`default_nettype none

module wft_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wft_pkg::wft_sts_t sts,
  output wft_pkg::wft_cmd_t cmd
);
  import wft_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_PREP      = 13'b0000000000010,
    S_NORM_PRE  = 13'b0000000000100,
    S_TICK      = 13'b0000000001000,
    S_STEP_LD   = 13'b0000000010000,
    S_STEP_DIV  = 13'b0000000100000,
    S_APPLY     = 13'b0000001000000,
    S_LINE_DIV  = 13'b0000010000000,
    S_NORM_POST = 13'b0000100000000,
    S_COL_MUL   = 13'b0001000000000,
    S_COL_LD    = 13'b0010000000000,
    S_COL_DIV   = 13'b0100000000000,
    S_OUT       = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_op = DIV_STEP;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: state_nxt = S_NORM_PRE;
      S_NORM_PRE: begin
        if (sts.norm_adv) begin
          cmd.norm_adv = 1'b1;
        end else begin
          state_nxt = S_TICK;
        end
      end
      S_TICK: begin
        cmd.tick = 1'b1;
        if (sts.seg_done) begin
          state_nxt = S_OUT;
        end else if (sts.seg_image) begin
          state_nxt = S_STEP_LD;
        end else begin
          state_nxt = S_APPLY;
        end
      end
      S_STEP_LD: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_STEP;
        state_nxt     = S_STEP_DIV;
      end
      S_STEP_DIV: begin
        if (!sts.div_busy) begin
          cmd.step_fix = 1'b1;
          state_nxt    = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (sts.line_adv && !sts.line_fast) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_LINE;
          state_nxt     = S_LINE_DIV;
        end else begin
          cmd.line_fast = sts.line_adv;
          state_nxt     = S_NORM_POST;
        end
      end
      S_LINE_DIV: begin
        if (!sts.div_busy) begin
          cmd.line_div_upd = 1'b1;
          state_nxt        = S_NORM_POST;
        end
      end
      S_NORM_POST: begin
        if (sts.norm_adv) begin
          cmd.norm_adv = 1'b1;
        end else if (sts.col_needed) begin
          state_nxt = S_COL_MUL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_COL_MUL: begin
        if (sts.col_clamp) begin
          cmd.col_clamp = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmd.col_mul = 1'b1;
          state_nxt   = S_COL_LD;
        end
      end
      S_COL_LD: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_COL;
        state_nxt     = S_COL_DIV;
      end
      S_COL_DIV: begin
        if (!sts.div_busy) begin
          cmd.col_fix = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result beat valid flag
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/wefax_fm_tone_generator.sv =====
// Weather-fax FM tone generator: one audio sample per input beat, one result beat each.
// Lead, tail and phasing beats skip the gray-to-step divide by 255 that image beats run;
// a beat whose next tick needs a column also runs the column divide in the shared divider.
// A new input beat is taken only after the previous result beat is loaded, and a stalled
// result side holds it back; a tick that passes a second line end (a line under one
// sample, or a position past a shortened line) runs the full line divide, and each
// skipped segment adds a normalize step.
// Reset (rst_n, synchronous): sequencer at lead, counters and phase zero, config defaults.
`default_nettype none

module wefax_fm_tone_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  wft_in_if.sink                         in_ch,
  wft_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [wft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wft_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wft_pkg::*;

  wft_cmd_t cmd;
  wft_sts_t sts;

  // Controller
  wft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  wft_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_gray              (in_ch.gray),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_sample           (out_ch.sample),
    .out_segment          (out_ch.segment),
    .out_next_col         (out_ch.next_col),
    .out_next_row         (out_ch.next_row),
    .out_next_needs_pixel (out_ch.next_needs_pixel)
  );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the weather-fax FM tone generator: directed and random ticks checked
// against a cycle-free model.
`default_nettype none

module tb;
  import wft_pkg::*;

  localparam real         TONE_PEAK = 18022.0;
  localparam real         TWO_PI    = 6.28318530717958647692;
  localparam int unsigned ROW_CAP   = 16383;

  // Expected result of one tick
  typedef struct packed {
    logic signed [15:0] sample;
    seg_t               segment;
    logic [10:0]        col;
    logic [13:0]        row;
    logic               needs_pixel;
  } tone_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  calm;      // no idling on either side while set
  logic                  hold_req;  // asks the result side for one long stall

  int    errors;
  tone_t tones_due[$];

  // Model copy of the registers
  longint unsigned r_lead, r_line_q8, r_rows, r_cols, r_tail, r_black, r_white;

  // Model copy of the sequencer state
  logic [31:0]        m_phase;
  seg_t               m_seg;
  longint unsigned    m_count, m_pos_q8, m_row;
  logic signed [15:0] sine_tab [0:4095];

  wft_in_if  in_ch ();
  wft_out_if out_ch ();

  wefax_fm_tone_generator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- model

  task automatic reset_model();
    int q;
    int mag;
    for (int p = 0; p < 4096; p++) begin
      if (p <= 1024) q = p;
      else if (p <= 2048) q = 2048 - p;
      else if (p <= 3072) q = p - 2048;
      else q = 4096 - p;
      mag = $rtoi(TONE_PEAK * $sin(TWO_PI * q / 4096.0) + 0.5);
      sine_tab[p] = (p <= 2048) ? 16'(mag) : 16'(-mag);
    end
    r_lead    = 96000;
    r_line_q8 = 6144000;
    r_rows    = 1;
    r_cols    = 800;
    r_tail    = 72000;
    r_black   = 134217728;
    r_white   = 205802087;
    m_phase   = '0;
    m_seg     = SEG_LEAD;
    m_count   = 0;
    m_pos_q8  = 0;
    m_row     = 0;
  endtask

  function automatic longint unsigned rows_used();
    if (r_rows < 1) return 1;
    return (r_rows > ROW_CAP) ? ROW_CAP : r_rows;
  endfunction

  function automatic longint unsigned cols_used();
    if (r_cols < MIN_WIDTH) return MIN_WIDTH;
    return (r_cols > MAX_WIDTH) ? MAX_WIDTH : r_cols;
  endfunction

  function automatic longint unsigned seg_span(seg_t s);
    case (s)
      SEG_LEAD:    return r_lead;
      SEG_PHASING: return (r_line_q8 + 32) >> 6;
      SEG_IMAGE:   return (r_line_q8 * rows_used() + 255) >> 8;
      SEG_TAIL:    return r_tail;
      default:     return 0;
    endcase
  endfunction

  // Skip every segment whose count already reached its length (empty ones too)
  task automatic settle_segment();
    while (m_seg != SEG_DONE && m_count >= seg_span(m_seg)) begin
      m_seg    = seg_t'(m_seg + 3'd1);
      m_count  = 0;
      m_pos_q8 = 0;
      m_row    = 0;
    end
  endtask

  // One audio tick: expected sample, segment and next pixel request
  task automatic predict_tone(input logic [7:0] g);
    longint          diff, prod, adj;
    longint unsigned t, nl, w, h, c;
    logic [31:0]     inc;
    seg_t            s;
    tone_t           res;
    settle_segment();
    s           = m_seg;
    res         = '0;
    res.segment = s;
    if (s != SEG_DONE) begin
      if (s == SEG_PHASING) begin
        inc = (m_pos_q8 * 25 < 2 * r_line_q8) ? 32'(r_black) : 32'(r_white);
      end else if (s == SEG_IMAGE) begin
        // gray maps linearly between black and white, rounded half away from zero
        diff = longint'(r_white) - longint'(r_black);
        prod = longint'(g) * diff;
        adj  = (prod >= 0) ? (prod + 127) / 255 : -((-prod + 127) / 255);
        inc  = 32'(longint'(r_black) + adj);
      end else begin
        inc = 32'((r_black + r_white) >> 1);
      end
      res.sample = sine_tab[m_phase[31:20]];
      m_phase    = m_phase + inc;
      m_count++;
      if ((s == SEG_PHASING || s == SEG_IMAGE) && r_line_q8 != 0) begin
        t        = m_pos_q8 + 256;
        nl       = m_row + t / r_line_q8;
        m_pos_q8 = t % r_line_q8;
        m_row    = (nl > ROW_CAP) ? ROW_CAP : nl;
      end
      settle_segment();
    end
    if (m_seg == SEG_IMAGE && r_line_q8 != 0) begin
      w = cols_used();
      h = rows_used();
      c = m_pos_q8 * w / r_line_q8;
      if (c > w - 1) c = w - 1;
      res.col         = 11'(c);
      res.row         = 14'((m_row > h - 1) ? h - 1 : m_row);
      res.needs_pixel = 1'b1;
    end
    tones_due.push_back(res);
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic set_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_LEAD_LEN:    r_lead    = val[19:0];
      CFG_LINE_LEN:    r_line_q8 = val[27:0];
      CFG_IMAGE_LINES: r_rows    = val[13:0];
      CFG_IMAGE_WIDTH: r_cols    = val[10:0];
      CFG_TAIL_LEN:    r_tail    = val[19:0];
      CFG_BLACK_STEP:  r_black   = val;
      CFG_WHITE_STEP:  r_white   = val;
      default: ;
    endcase
  endtask

  // Offer one tick beat; valid stays high into the next beat unless a gap is taken
  task automatic send_tick(input logic [7:0] g);
    if (!calm && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.gray  <= g;
    do @(posedge clk); while (!in_ch.ready);
    predict_tone(g);
  endtask

  // Stop offering and wait until every expected result has come
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tones_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic flag_field(input string what, input logic signed [31:0] want,
                            input logic signed [31:0] got);
    errors++;
    $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : result_sink
    int    hold_left;
    tone_t want;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (tones_due.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat: sample %0d segment %0d", $time,
                   out_ch.sample, out_ch.segment);
        end else begin
          want = tones_due.pop_front();
          if (out_ch.sample !== want.sample)
            flag_field("sample", $signed(want.sample), $signed(out_ch.sample));
          if (out_ch.segment !== want.segment)
            flag_field("segment", want.segment, out_ch.segment);
          if (out_ch.next_col !== want.col)
            flag_field("next_col", want.col, out_ch.next_col);
          if (out_ch.next_row !== want.row)
            flag_field("next_row", want.row, out_ch.next_row);
          if (out_ch.next_needs_pixel !== want.needs_pixel)
            flag_field("next_needs_pixel", want.needs_pixel, out_ch.next_needs_pixel);
        end
      end
      // long stall on request, otherwise random ready
      if (hold_req && hold_left == 0) begin
        hold_left = 300;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Short lead, then cut it off mid-way by writing a zero length
  task automatic test_lead_cut();
    set_reg(CFG_LEAD_LEN, 6);
    set_reg(CFG_LINE_LEN, 640);
    set_reg(CFG_IMAGE_LINES, ROW_CAP);
    set_reg(CFG_IMAGE_WIDTH, MAX_WIDTH);
    set_reg(CFG_TAIL_LEN, 24);
    set_reg(CFG_BLACK_STEP, 32'h0000_0000);
    set_reg(CFG_WHITE_STEP, 32'hFFFF_FFFF);
    repeat (3) send_tick(8'($urandom_range(255)));
    wait_idle();
    set_reg(CFG_LEAD_LEN, 0);
  endtask

  // Four lines of 2.5 samples: black at the start of each line, white after
  task automatic test_phasing();
    do send_tick(8'($urandom_range(255))); while (m_seg == SEG_PHASING);
    wait_idle();
  endtask

  // Gray extremes with the white step above, then below the black step
  task automatic test_gray_extremes();
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'h55);
    send_tick(8'hAA);
    wait_idle();
    set_reg(CFG_BLACK_STEP, 32'hFFFF_FFFF);
    set_reg(CFG_WHITE_STEP, 32'h0000_0000);
    send_tick(8'hFF);
    send_tick(8'h00);
    wait_idle();
  endtask

  // One sample per line, then fewer rows than already sent: row clamps to the last
  task automatic test_row_clamp();
    set_reg(CFG_LINE_LEN, 256);
    set_reg(CFG_IMAGE_WIDTH, MIN_WIDTH);
    repeat (4) send_tick(8'($urandom_range(255)));
    wait_idle();
    set_reg(CFG_LINE_LEN, 1 << 20);
    set_reg(CFG_IMAGE_LINES, 3);
    repeat (2) send_tick(8'($urandom_range(255)));
    wait_idle();
    set_reg(CFG_IMAGE_LINES, ROW_CAP);
  endtask

  // Longest line, then a short one: position wraps and several rows pass at once
  task automatic test_line_shrink();
    set_reg(CFG_LINE_LEN, 28'hFFF_FFFF);
    repeat (3) send_tick(8'($urandom_range(255)));
    wait_idle();
    set_reg(CFG_LINE_LEN, 300);
    repeat (3) send_tick(8'($urandom_range(255)));
    wait_idle();
  endtask

  // Image ticks under a series of settings; rows stay far above the ticks sent
  task automatic test_image_random();
    logic [31:0] len_q8, blk, wht;
    for (int k = 0; k < 13; k++) begin
      wait_idle();
      case (k % 6)
        0:       len_q8 = 256;
        1:       len_q8 = $urandom_range(511, 257);
        2:       len_q8 = 28'hFFF_FFFF;
        default: len_q8 = $urandom_range(8192, 512);
      endcase
      blk = $urandom();
      wht = $urandom();
      if (k == 0) begin
        blk = 32'h0000_0000;
        wht = 32'hFFFF_FFFF;
      end else if (k == 1) begin
        blk = 32'hFFFF_FFFF;
        wht = 32'h0000_0000;
      end else if (k == 2) begin
        wht = blk;
      end
      set_reg(CFG_LINE_LEN, len_q8);
      set_reg(CFG_IMAGE_WIDTH, (k % 4 == 0) ? MIN_WIDTH :
                               (k % 4 == 1) ? MAX_WIDTH : $urandom_range(1599, 161));
      set_reg(CFG_IMAGE_LINES, (k == 3) ? ROW_CAP : $urandom_range(ROW_CAP, 4000));
      set_reg(CFG_BLACK_STEP, blk);
      set_reg(CFG_WHITE_STEP, wht);
      calm <= (k == 5);
      repeat (120) send_tick(8'($urandom_range(255)));
    end
    wait_idle();
    calm <= 1'b0;
  endtask

  // Result side stalls long while ticks keep coming, then the sender waits it out
  task automatic test_backpressure();
    hold_req <= 1'b1;
    repeat (40) send_tick(8'($urandom_range(255)));
    wait_idle();
  endtask

  // Image ends, tail runs, tail is cut, then the block stays finished
  task automatic test_tail_done();
    set_reg(CFG_IMAGE_LINES, 1);
    set_reg(CFG_LINE_LEN, 2600);
    set_reg(CFG_TAIL_LEN, 24);
    repeat (10) send_tick(8'($urandom_range(255)));
    wait_idle();
    set_reg(CFG_TAIL_LEN, 0);
    repeat (6) send_tick(8'($urandom_range(255)));
    wait_idle();
    set_reg(CFG_LEAD_LEN, 20'hF_FFFF);
    set_reg(CFG_TAIL_LEN, 20'hF_FFFF);
    set_reg(CFG_LINE_LEN, 28'hFFF_FFFF);
    set_reg(CFG_IMAGE_LINES, ROW_CAP);
    set_reg(CFG_IMAGE_WIDTH, MAX_WIDTH);
    set_reg(CFG_BLACK_STEP, 32'hFFFF_FFFF);
    set_reg(CFG_WHITE_STEP, 32'hFFFF_FFFF);
    repeat (4) send_tick(8'($urandom_range(255)));
    wait_idle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : run
    errors = 0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.gray  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_LEAD_LEN;
    cfg_wdata   <= '0;
    calm        <= 1'b0;
    hold_req    <= 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_lead_cut();
    test_phasing();
    test_gray_extremes();
    test_row_clamp();
    test_line_shrink();
    test_image_random();
    test_backpressure();
    test_tail_done();

    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
